/* rtl/h263d_pkg.sv */
// h263d_pkg: shared types, constants and header decode helpers for the
// h.263 rtp depacketizer; no dependencies, used by every rtl file
`timescale 1ns / 1ps

package h263d_pkg;

  // payload header modes (f and p bits of the first byte)
  typedef enum logic [1:0] {
    MODE_A = 2'd0,
    MODE_B = 2'd1,
    MODE_C = 2'd2
  } mode_t;

  // first header byte fields
  localparam logic [7:0] F_BIT     = 8'h80;
  localparam logic [7:0] P_BIT     = 8'h40;
  localparam logic [7:0] SBIT_MASK = 8'h38;
  localparam logic [7:0] EBIT_MASK = 8'h07;
  localparam int         SBIT_LSB  = 3;

  // header lengths in bytes
  localparam logic [3:0] HLEN_A = 4'd4;
  localparam logic [3:0] HLEN_B = 4'd8;
  localparam logic [3:0] HLEN_C = 4'd12;

  // header position saturates here
  localparam logic [3:0] HPOS_MAX = 4'hF;

  // picture start code check and ptype coding type bit
  localparam logic [7:0] PSC_MASK     = 8'hFC;
  localparam logic [7:0] PSC_BYTE2    = 8'h80;
  localparam logic [7:0] PTYPE_I_MASK = 8'h02;
  localparam logic [7:0] BYTE_ALL     = 8'hFF;

  // lookahead of the frame opening packet
  localparam int         LA_N    = 5;
  localparam int         LA_IW   = $clog2(LA_N - 1);
  localparam logic [2:0] LA_LAST = 3'(LA_N - 1);

  // command queue depth
  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);

  // one command from the front end to the back end
  typedef struct packed {
    logic                      abort;      // discontinuity on a first byte
    logic                      set_inter;  // frame opens, load the inter flag
    logic                      inter;
    logic                      first_pay;  // first byte is a packet's first payload byte
    logic                      last;       // last byte is the packet's last byte
    logic                      frame_end;  // marker closes the open frame
    logic [2:0]                sbit;
    logic [2:0]                ebit;
    logic [2:0]                pay_cnt;    // payload bytes carried, 0..LA_N
    logic [LA_N-1:0][7:0]      bytes;
    logic [31:0]               ts;
  } cmd_t;

  // mode from the first header byte
  function automatic mode_t mode_decode(input logic [7:0] b);
    mode_t m;
    if ((b & F_BIT) == '0) begin
      m = MODE_A;
    end else if ((b & P_BIT) == '0) begin
      m = MODE_B;
    end else begin
      m = MODE_C;
    end
    return m;
  endfunction

  // header length of a mode
  function automatic logic [3:0] hdr_len(input mode_t m);
    logic [3:0] l;
    case (m)
      MODE_A:  l = HLEN_A;
      MODE_B:  l = HLEN_B;
      MODE_C:  l = HLEN_C;
      default: l = HLEN_C;
    endcase
    return l;
  endfunction

endpackage

/* rtl/h263_rtp_depacketizer_core.sv */
// h263_rtp_depacketizer_core: top level of the h.263 (rfc 2190) rtp depacketizer
// depends on h263d_pkg, h263d_front, h263d_cmd_q, h263d_back
`timescale 1ns / 1ps

// Takes rtp payload bytes one item per cycle, header bytes included, and
// returns the rebuilt h.263 bitstream one item per cycle while the receiver
// is ready. The parser takes an input item in every cycle in which its
// four-entry command queue has room; it only stalls when the emitter falls
// behind. Each ordinary payload byte is one emitter step and leaves one byte
// delayed by one item, so that the last byte of a frame carries frame_end.
// The packet that opens a frame is held until its fifth payload byte proves
// a picture start code, and the emitter then steps through those bytes; a
// marker adds the end item. Results sit in an output register, so input keeps
// flowing while a result waits to be taken. There is no clearing pass.

module h263_rtp_depacketizer_core import h263d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_payload_byte,
  input  logic        in_first_of_packet,
  input  logic        in_last_of_packet,
  input  logic        in_marker_bit,
  input  logic        in_discontinuity,
  input  logic [31:0] in_rtp_timestamp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_frame_end,
  output logic        out_frame_aborted,
  output logic        out_inter_coded,
  output logic [31:0] out_frame_timestamp
);

  cmd_t push_cmd;
  cmd_t head;
  logic push;
  logic full;
  logic pop;
  logic head_valid;

  // parser
  h263d_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_payload_byte    (in_payload_byte),
    .in_first_of_packet (in_first_of_packet),
    .in_last_of_packet  (in_last_of_packet),
    .in_marker_bit      (in_marker_bit),
    .in_discontinuity   (in_discontinuity),
    .in_rtp_timestamp   (in_rtp_timestamp),
    .q_full             (full),
    .cmd_push           (push),
    .cmd                (push_cmd)
  );

  // command queue
  h263d_cmd_q u_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // emitter
  h263d_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head_valid          (head_valid),
    .head                (head),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_byte            (out_byte),
    .out_byte_valid      (out_byte_valid),
    .out_frame_end       (out_frame_end),
    .out_frame_aborted   (out_frame_aborted),
    .out_inter_coded     (out_inter_coded),
    .out_frame_timestamp (out_frame_timestamp)
  );

endmodule

/* rtl/h263d_front.sv */
// h263d_front: per-byte packet parser; tracks header position, mode, sbit/ebit,
// picture start lookahead and frame open state, and issues commands
// depends on h263d_pkg
`timescale 1ns / 1ps

module h263d_front import h263d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_payload_byte,
  input  logic        in_first_of_packet,
  input  logic        in_last_of_packet,
  input  logic        in_marker_bit,
  input  logic        in_discontinuity,
  input  logic [31:0] in_rtp_timestamp,
  input  logic        q_full,
  output logic        cmd_push,
  output cmd_t        cmd
);

  logic       frame_open_r, frame_open_nxt;
  logic       in_packet_r, in_packet_nxt;
  logic [3:0] hdr_pos_r, hdr_pos_nxt;
  mode_t      mode_r, mode_nxt;
  logic [2:0] sbit_r, sbit_nxt;
  logic [2:0] ebit_r, ebit_nxt;
  logic [2:0] la_cnt_r, la_cnt_nxt;
  logic       skip_r, skip_nxt;
  logic [7:0] la_r [LA_N-1];
  logic [7:0] la_nxt [LA_N-1];

  logic       acc;
  logic [7:0] b;
  logic       first;
  logic       open_e;
  logic       skip_e;
  logic [2:0] la_cnt_e;
  logic [3:0] p;
  logic [3:0] hlen;
  logic       psc_ok;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign b        = in_payload_byte;
  assign first    = in_first_of_packet;

  // picture start code over the stored bytes
  assign psc_ok = (la_r[0] == '0) && (la_r[1] == '0) && ((la_r[2] & PSC_MASK) == PSC_BYTE2);

  // classify the byte and build its command
  always_comb begin
    frame_open_nxt = frame_open_r;
    in_packet_nxt  = in_packet_r;
    hdr_pos_nxt    = hdr_pos_r;
    mode_nxt       = mode_r;
    sbit_nxt       = sbit_r;
    ebit_nxt       = ebit_r;
    la_cnt_nxt     = la_cnt_r;
    skip_nxt       = skip_r;
    la_nxt         = la_r;

    cmd       = '0;
    cmd.last  = in_last_of_packet;
    cmd.ts    = in_rtp_timestamp;

    // packet start: decode first header byte
    if (first) begin
      if (in_discontinuity) begin
        cmd.abort      = 1'b1;
        frame_open_nxt = 1'b0;
      end
      in_packet_nxt = 1'b1;
      la_cnt_nxt    = '0;
      skip_nxt      = 1'b0;
      mode_nxt      = mode_decode(b);
      sbit_nxt      = 3'((b & SBIT_MASK) >> SBIT_LSB);
      ebit_nxt      = 3'(b & EBIT_MASK);
    end

    cmd.sbit = sbit_nxt;
    cmd.ebit = ebit_nxt;
    open_e   = frame_open_nxt;
    skip_e   = skip_nxt;
    la_cnt_e = la_cnt_nxt;
    p        = first ? '0 : hdr_pos_r;
    hlen     = hdr_len(mode_nxt);

    if (first || in_packet_r) begin
      hdr_pos_nxt = (p != HPOS_MAX) ? p + 4'd1 : p;

      // payload byte
      if (p >= hlen && !skip_e) begin
        if (open_e) begin
          cmd.pay_cnt   = 3'd1;
          cmd.bytes[0]  = b;
          cmd.first_pay = (p == hlen);
        end else if (mode_nxt != MODE_A) begin
          skip_nxt = 1'b1;
        end else if (la_cnt_e < 3'(LA_N)) begin
          la_cnt_nxt = la_cnt_e + 3'd1;
          if (la_cnt_e == LA_LAST) begin
            if (psc_ok) begin
              frame_open_nxt = 1'b1;
              cmd.set_inter  = 1'b1;
              cmd.inter      = (b & PTYPE_I_MASK) != '0;
              cmd.pay_cnt    = 3'(LA_N);
              cmd.first_pay  = 1'b1;
              for (int i = 0; i < LA_N - 1; i++) begin
                cmd.bytes[i] = la_r[i];
              end
              cmd.bytes[LA_N-1] = b;
            end else begin
              skip_nxt = 1'b1;
            end
          end else begin
            la_nxt[la_cnt_e[LA_IW-1:0]] = b;
          end
        end else begin
          skip_nxt = 1'b1;
        end
      end

      // packet end, marker closes or re-arms the frame
      if (in_last_of_packet) begin
        in_packet_nxt = 1'b0;
        if (({1'b0, p} + 5'd1 >= {1'b0, hlen}) && in_marker_bit) begin
          if (frame_open_nxt) begin
            cmd.frame_end  = 1'b1;
            frame_open_nxt = 1'b0;
          end else begin
            frame_open_nxt = 1'b1;
          end
        end
      end
    end
  end

  assign cmd_push = acc && (cmd.abort || (cmd.pay_cnt != '0) || cmd.frame_end);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b1;
      in_packet_r  <= 1'b0;
      hdr_pos_r    <= '0;
      mode_r       <= MODE_A;
      sbit_r       <= '0;
      ebit_r       <= '0;
      la_cnt_r     <= '0;
      skip_r       <= 1'b0;
    end else if (acc) begin
      frame_open_r <= frame_open_nxt;
      in_packet_r  <= in_packet_nxt;
      hdr_pos_r    <= hdr_pos_nxt;
      mode_r       <= mode_nxt;
      sbit_r       <= sbit_nxt;
      ebit_r       <= ebit_nxt;
      la_cnt_r     <= la_cnt_nxt;
      skip_r       <= skip_nxt;
    end
  end

  // lookahead bytes, valid only below la_cnt_r
  always_ff @(posedge clk) begin
    if (acc) begin
      la_r <= la_nxt;
    end
  end

endmodule

/* rtl/h263d_cmd_q.sv */
// h263d_cmd_q: small fifo of commands between the parser and the emitter
// depends on h263d_pkg
`timescale 1ns / 1ps

module h263d_cmd_q import h263d_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  cmd_t             mem [QDEPTH];
  logic [QPW-1:0]   wr_ptr_r;
  logic [QPW-1:0]   rd_ptr_r;
  logic [QPW:0]     count_r;

  assign full       = (count_r == (QPW + 1)'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // no write into a full queue, no read from an empty one
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("command queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
    else $error("command queue underflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (QPW'(wr_ptr_r - rd_ptr_r) == count_r[QPW-1:0]))
    else $error("command queue pointers disagree with count");

endmodule

/* rtl/h263d_back.sv */
// h263d_back: command executor; holds the delayed byte, the ebit/sbit partial
// byte and the inter flag, and drives the registered result channel
// depends on h263d_pkg
`timescale 1ns / 1ps

module h263d_back import h263d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  cmd_t        head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_frame_end,
  output logic        out_frame_aborted,
  output logic        out_inter_coded,
  output logic [31:0] out_frame_timestamp
);

  logic [7:0]  held_byte_r, held_byte_nxt;
  logic        held_valid_r, held_valid_nxt;
  logic [7:0]  partial_r, partial_nxt;
  logic        pend_r, pend_nxt;
  logic        has_out_r, has_out_nxt;
  logic        inter_r, inter_nxt;
  logic [2:0]  idx_r, idx_nxt;

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_byte_valid_r;
  logic        out_frame_end_r;
  logic        out_frame_aborted_r;
  logic        out_inter_coded_r;
  logic [31:0] out_frame_timestamp_r;

  logic        emit;
  logic        done;
  logic        fire;
  logic        load_ok;
  logic [7:0]  it_byte;
  logic        it_valid;
  logic        it_end;
  logic        it_abort;
  logic [31:0] it_ts;
  logic [7:0]  v;
  logic        fp;
  logic        lst;

  assign load_ok = !out_valid_r || out_ready;

  // one step of the head command
  always_comb begin
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    partial_nxt    = partial_r;
    pend_nxt       = pend_r;
    has_out_nxt    = has_out_r;
    inter_nxt      = inter_r;
    idx_nxt        = idx_r;
    emit           = 1'b0;
    done           = 1'b0;
    it_byte        = '0;
    it_valid       = 1'b0;
    it_end         = 1'b0;
    it_abort       = 1'b0;
    it_ts          = '0;
    v              = '0;
    fp             = 1'b0;
    lst            = 1'b0;

    if (head.set_inter && idx_r == '0) begin
      inter_nxt = head.inter;
    end

    if (head.abort) begin
      // discontinuity: abort item if the frame had bytes, then clear
      emit           = has_out_r;
      it_abort       = 1'b1;
      held_valid_nxt = 1'b0;
      partial_nxt    = '0;
      pend_nxt       = 1'b0;
      has_out_nxt    = 1'b0;
      done           = 1'b1;
      idx_nxt        = '0;
    end else if (idx_r < head.pay_cnt) begin
      // payload byte: sbit merge, ebit split, else push through the delay
      v   = (idx_r < 3'(LA_N)) ? head.bytes[idx_r[2:0]] : '0;
      fp  = head.first_pay && (idx_r == '0);
      lst = head.last && (idx_r == head.pay_cnt - 3'd1);
      if (fp && head.sbit != '0) begin
        v           = (v & (BYTE_ALL >> head.sbit)) | partial_r;
        partial_nxt = '0;
        pend_nxt    = 1'b0;
      end
      if (lst && head.ebit != '0) begin
        partial_nxt = v & (BYTE_ALL << head.ebit);
        pend_nxt    = 1'b1;
      end else begin
        emit           = held_valid_r;
        it_byte        = held_byte_r;
        it_valid       = 1'b1;
        held_byte_nxt  = v;
        held_valid_nxt = 1'b1;
        has_out_nxt    = 1'b1;
      end
      if (idx_r == head.pay_cnt - 3'd1 && !head.frame_end) begin
        done    = 1'b1;
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end else begin
      // frame end: flush held byte ahead of a pending partial, then end item
      emit = 1'b1;
      if (pend_r && held_valid_r) begin
        it_byte        = held_byte_r;
        it_valid       = 1'b1;
        held_valid_nxt = 1'b0;
      end else begin
        it_end = 1'b1;
        it_ts  = head.ts;
        if (pend_r) begin
          it_byte  = partial_r;
          it_valid = 1'b1;
        end else if (held_valid_r) begin
          it_byte  = held_byte_r;
          it_valid = 1'b1;
        end
        held_valid_nxt = 1'b0;
        partial_nxt    = '0;
        pend_nxt       = 1'b0;
        has_out_nxt    = 1'b0;
        done           = 1'b1;
        idx_nxt        = '0;
      end
    end
  end

  assign fire = head_valid && (!emit || load_ok);
  assign pop  = fire && done;

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      partial_r    <= '0;
      pend_r       <= 1'b0;
      has_out_r    <= 1'b0;
      inter_r      <= 1'b0;
      idx_r        <= '0;
    end else if (fire) begin
      held_valid_r <= held_valid_nxt;
      partial_r    <= partial_nxt;
      pend_r       <= pend_nxt;
      has_out_r    <= has_out_nxt;
      inter_r      <= inter_nxt;
      idx_r        <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      held_byte_r <= held_byte_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_byte_r            <= it_valid ? it_byte : '0;
      out_byte_valid_r      <= it_valid;
      out_frame_end_r       <= it_end;
      out_frame_aborted_r   <= it_abort;
      out_inter_coded_r     <= inter_nxt;
      out_frame_timestamp_r <= it_ts;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_byte            = out_byte_r;
  assign out_byte_valid      = out_byte_valid_r;
  assign out_frame_end       = out_frame_end_r;
  assign out_frame_aborted   = out_frame_aborted_r;
  assign out_inter_coded     = out_inter_coded_r;
  assign out_frame_timestamp = out_frame_timestamp_r;

  // an item is never both an end and an abort
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_frame_end_r && out_frame_aborted_r))
    else $error("item marked both frame end and abort");
  // a held byte always belongs to a frame that has output
  assert property (@(posedge clk) disable iff (!rst_n) !has_out_r |-> !held_valid_r)
    else $error("held byte outside a frame with output");
  // the partial byte is clear unless pending, so the sbit merge is safe
  assert property (@(posedge clk) disable iff (!rst_n) !pend_r |-> (partial_r == '0))
    else $error("stale partial byte");
  // step index never runs past the command's payload
  assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (idx_r <= head.pay_cnt))
    else $error("step index beyond command payload");

endmodule

/* tb/h263d_tb_pkg.sv */
// h263d_tb_pkg: item types and the frame rebuild checker for the h.263 rtp
// depacketizer testbench; depends on h263d_pkg for the payload header modes
`timescale 1ns / 1ps

package h263d_tb_pkg;
  import h263d_pkg::*;

  // one input item as driven on the in_ channel
  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic        marker;
    logic        disc;
    logic [31:0] ts;
  } in_item_t;

  // one rebuilt bitstream item as seen on the out_ channel
  typedef struct packed {
    logic [7:0]  data;
    logic        data_valid;
    logic        frame_end;
    logic        aborted;
    logic        inter;
    logic [31:0] ts;
  } out_item_t;

  class h263d_stream_checker;
    // mirrored depacketizer state
    bit        frm_open;
    bit        frm_inter;
    bit [7:0]  partial;
    bit        partial_pend;
    bit [3:0]  hdr_pos;
    mode_t     pkt_mode;
    bit [2:0]  sbit;
    bit [2:0]  ebit;
    bit [7:0]  psc_buf[5];
    int        psc_cnt;
    bit [7:0]  held;
    bit        held_v;
    bit        skipping;
    bit        frm_has_data;
    bit        in_pkt;
    int        step_cnt;
    out_item_t rebuilt_q[$];
    int        errors;

    function new();
      frm_open = 1;
      frm_inter = 0;
      partial = 0;
      partial_pend = 0;
      hdr_pos = 0;
      pkt_mode = MODE_A;
      sbit = 0;
      ebit = 0;
      psc_cnt = 0;
      held = 0;
      held_v = 0;
      skipping = 0;
      frm_has_data = 0;
      in_pkt = 0;
      errors = 0;
    endfunction

    function int pending();
      return rebuilt_q.size();
    endfunction

    // at most six items come out of one input item
    function void queue_item(bit [7:0] d, bit dv, bit fe, bit ab, bit [31:0] ts);
      out_item_t o;
      if (step_cnt >= 6) return;
      o.data = dv ? d : 8'h00;
      o.data_valid = dv;
      o.frame_end = fe;
      o.aborted = ab;
      o.inter = frm_inter;
      o.ts = fe ? ts : 32'h0;
      rebuilt_q.push_back(o);
      step_cnt++;
    endfunction

    function void drop_frame();
      held_v = 0;
      partial = 0;
      partial_pend = 0;
      frm_has_data = 0;
    endfunction

    // sbit merge on the first payload byte, ebit split on the last one,
    // everything else goes through the one-byte hold
    function void take_payload(bit [7:0] v, bit first_pay, bit last_pay);
      if (first_pay && sbit != 0) begin
        v = (v & (8'hFF >> sbit)) | partial;
        partial = 0;
        partial_pend = 0;
      end
      if (last_pay && ebit != 0) begin
        partial = v & (8'hFF << ebit);
        partial_pend = 1;
      end else begin
        if (held_v) queue_item(held, 1, 0, 0, 0);
        held = v;
        held_v = 1;
        frm_has_data = 1;
      end
    endfunction

    // one accepted input item, expected output items go to rebuilt_q
    function void accept_byte(in_item_t it);
      bit [3:0] hlen;
      bit [3:0] p;
      int       i;
      step_cnt = 0;
      if (it.first) begin
        if (it.disc) begin
          if (frm_has_data) queue_item(0, 0, 0, 1, 0);
          drop_frame();
          frm_open = 0;
        end
        in_pkt = 1;
        hdr_pos = 0;
        psc_cnt = 0;
        skipping = 0;
        if (!it.data[7]) pkt_mode = MODE_A;
        else if (!it.data[6]) pkt_mode = MODE_B;
        else pkt_mode = MODE_C;
        sbit = it.data[5:3];
        ebit = it.data[2:0];
      end
      if (!in_pkt) return;

      case (pkt_mode)
        MODE_A:  hlen = 4'd4;
        MODE_B:  hlen = 4'd8;
        default: hlen = 4'd12;
      endcase
      p = hdr_pos;
      if (hdr_pos != 4'hF) hdr_pos++;

      // payload: straight into the frame, or held until the start code shows
      if (p >= hlen && !skipping) begin
        if (frm_open) begin
          take_payload(it.data, p == hlen, it.last);
        end else if (pkt_mode != MODE_A || psc_cnt >= 5) begin
          skipping = 1;
        end else begin
          psc_buf[psc_cnt] = it.data;
          psc_cnt++;
          if (psc_cnt == 5) begin
            if (psc_buf[0] == 0 && psc_buf[1] == 0 && (psc_buf[2] & 8'hFC) == 8'h80) begin
              frm_open = 1;
              frm_inter = psc_buf[4][1];
              for (i = 0; i < 5; i++) take_payload(psc_buf[i], i == 0, i == 4 && it.last);
            end else begin
              skipping = 1;
            end
          end
        end
      end

      // marker on a packet that covers its header
      if (it.last) begin
        in_pkt = 0;
        if (int'(p) + 1 >= int'(hlen) && it.marker) begin
          if (!frm_open) begin
            frm_open = 1;
          end else begin
            if (partial_pend) begin
              if (held_v) queue_item(held, 1, 0, 0, 0);
              queue_item(partial, 1, 1, 0, it.ts);
            end else if (held_v) begin
              queue_item(held, 1, 1, 0, it.ts);
            end else begin
              queue_item(0, 0, 1, 0, it.ts);
            end
            drop_frame();
            frm_open = 0;
          end
        end
      end
    endfunction

    // compare one accepted output item with the oldest expected one
    function void check_out_item(out_item_t got);
      out_item_t w;
      if (rebuilt_q.size() == 0) begin
        $error("unexpected item: out_byte %0h out_byte_valid %0b out_frame_end %0b",
               got.data, got.data_valid, got.frame_end);
        errors++;
        return;
      end
      w = rebuilt_q.pop_front();
      if (got.data !== w.data) begin
        $error("out_byte expected %0h actual %0h", w.data, got.data);
        errors++;
      end
      if (got.data_valid !== w.data_valid) begin
        $error("out_byte_valid expected %0b actual %0b", w.data_valid, got.data_valid);
        errors++;
      end
      if (got.frame_end !== w.frame_end) begin
        $error("out_frame_end expected %0b actual %0b", w.frame_end, got.frame_end);
        errors++;
      end
      if (got.aborted !== w.aborted) begin
        $error("out_frame_aborted expected %0b actual %0b", w.aborted, got.aborted);
        errors++;
      end
      if (got.inter !== w.inter) begin
        $error("out_inter_coded expected %0b actual %0b", w.inter, got.inter);
        errors++;
      end
      if (got.ts !== w.ts) begin
        $error("out_frame_timestamp expected %0h actual %0h", w.ts, got.ts);
        errors++;
      end
    endfunction
  endclass

endpackage

/* tb/tb_top.sv */
// tb_top: drives rtp payload packets into h263_rtp_depacketizer_core and checks
// the rebuilt h.263 stream; depends on h263d_pkg and h263d_tb_pkg
`timescale 1ns / 1ps

module tb_top;
  import h263d_pkg::*;
  import h263d_tb_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_payload_byte;
  logic        in_first_of_packet;
  logic        in_last_of_packet;
  logic        in_marker_bit;
  logic        in_discontinuity;
  logic [31:0] in_rtp_timestamp;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic        out_frame_end;
  logic        out_frame_aborted;
  logic        out_inter_coded;
  logic [31:0] out_frame_timestamp;

  h263d_stream_checker chk;
  logic [7:0]          pay_q[$];
  int                  n_sent;
  int                  burst_left;
  bit                  hold_req;

  h263_rtp_depacketizer_core u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_payload_byte     (in_payload_byte),
    .in_first_of_packet  (in_first_of_packet),
    .in_last_of_packet   (in_last_of_packet),
    .in_marker_bit       (in_marker_bit),
    .in_discontinuity    (in_discontinuity),
    .in_rtp_timestamp    (in_rtp_timestamp),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_byte            (out_byte),
    .out_byte_valid      (out_byte_valid),
    .out_frame_end       (out_frame_end),
    .out_frame_aborted   (out_frame_aborted),
    .out_inter_coded     (out_inter_coded),
    .out_frame_timestamp (out_frame_timestamp)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // run limit
  initial begin
    #2_000_000;
    $display("h263_rtp_depacketizer_core: mismatch");
    $finish;
  end

  // first header byte of a packet
  function automatic logic [7:0] hdr_first(mode_t m, logic [2:0] s, logic [2:0] e);
    return {m != MODE_A, m == MODE_C, s, e};
  endfunction

  // header length implied by a first header byte
  function automatic int hdr_bytes(logic [7:0] b0);
    return b0[7] ? (b0[6] ? 12 : 8) : 4;
  endfunction

  // offer one item, bursts of random length with random gaps in between
  task automatic send(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid           <= 1'b1;
    in_payload_byte    <= it.data;
    in_first_of_packet <= it.first;
    in_last_of_packet  <= it.last;
    in_marker_bit      <= it.marker;
    in_discontinuity   <= it.disc;
    in_rtp_timestamp   <= it.ts;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chk.accept_byte(it);
  endtask

  // byte with no packet around it, random flags
  task automatic send_stray();
    in_item_t it;
    it.data = 8'($urandom);
    it.first = 1'b0;
    it.last = 1'($urandom);
    it.marker = 1'($urandom);
    it.disc = 1'($urandom);
    it.ts = $urandom;
    send(it);
  endtask

  // header bytes then pay_q; a cut packet never gets its last flag
  task automatic send_packet(logic [7:0] hdr0, int n_hdr, bit mk, bit disc,
                             logic [31:0] ts, bit cut);
    in_item_t it;
    int       total;
    int       i;
    total = n_hdr + pay_q.size();
    for (i = 0; i < total; i++) begin
      it.data = (i == 0) ? hdr0 : (i < n_hdr) ? 8'($urandom) : pay_q[i - n_hdr];
      it.first = (i == 0);
      it.last = (i == total - 1) && !cut;
      it.marker = it.last ? mk : 1'($urandom);
      it.disc = (i == 0) ? disc : 1'($urandom);
      it.ts = it.last ? ts : $urandom;
      send(it);
      n_sent++;
    end
  endtask

  // stop offering until every expected item has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (chk.pending() != 0);
  endtask

  // well-formed frame: start code packet, then continuation packets, marker last
  task automatic send_frame();
    int         np;
    int         i;
    int         n;
    logic [7:0] b0;
    np = $urandom_range(0, 3);
    pay_q = {8'h00, 8'h00, {6'b100000, 2'($urandom)}, 8'($urandom), 8'($urandom)};
    n = $urandom_range(0, 6);
    repeat (n) pay_q.push_back(8'($urandom));
    send_packet(hdr_first(MODE_A, 3'($urandom), 3'($urandom)), 4, np == 0,
                $urandom_range(0, 3) == 0, $urandom, 1'b0);
    for (i = 1; i <= np; i++) begin
      if ($urandom_range(0, 7) == 0) send_stray();
      b0 = hdr_first(mode_t'($urandom_range(0, 2)), 3'($urandom), 3'($urandom));
      pay_q = {};
      n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      repeat (n) pay_q.push_back(8'($urandom));
      send_packet(b0, hdr_bytes(b0), i == np, $urandom_range(0, 15) == 0, $urandom,
                  $urandom_range(0, 11) == 0);
    end
  endtask

  // broken or odd packets
  task automatic send_noise();
    int         n;
    int         j;
    logic [7:0] b0;
    b0 = 8'($urandom);
    pay_q = {};
    case ($urandom_range(0, 3))
      0: begin
        // any header, random payload
        n = $urandom_range(0, 8);
        repeat (n) pay_q.push_back(8'($urandom));
        send_packet(b0, hdr_bytes(b0), 1'($urandom), $urandom_range(0, 2) == 0, $urandom, 1'b0);
      end
      1: begin
        // shorter than its header
        send_packet(b0, $urandom_range(1, hdr_bytes(b0) - 1), 1'b1, 1'($urandom),
                    $urandom, 1'b0);
      end
      2: begin
        // start code that is near-miss or too short to check
        pay_q = {8'h00, 8'h00, {6'b100000, 2'($urandom)}, 8'($urandom), 8'($urandom)};
        if ($urandom_range(0, 2) == 0) begin
          n = $urandom_range(0, 4);
          while (pay_q.size() > n) void'(pay_q.pop_back());
        end else begin
          j = $urandom_range(0, 2);
          if (j == 2) pay_q[2] = pay_q[2] ^ (8'h80 >> $urandom_range(0, 5));
          else pay_q[j] = pay_q[j] ^ (8'h01 << $urandom_range(0, 7));
          n = $urandom_range(0, 3);
          repeat (n) pay_q.push_back(8'($urandom));
        end
        send_packet(hdr_first(MODE_A, 3'($urandom), 3'($urandom)), 4, 1'($urandom),
                    1'($urandom), $urandom, 1'b0);
      end
      default: begin
        n = $urandom_range(1, 3);
        repeat (n) send_stray();
      end
    endcase
  endtask

  // receiver: rotating stall pattern plus one long hold-off
  initial begin
    int cyc;
    bit rdy;
    bit held_off;
    cyc = 0;
    held_off = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held_off) begin
        held_off = 1;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        cyc++;
        case ((cyc / 64) % 4)
          0:       rdy = 1'b1;
          1:       rdy = 1'($urandom);
          2:       rdy = (cyc % 3 == 0);
          default: rdy = ($urandom_range(0, 3) != 0);
        endcase
        out_ready <= rdy;
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      chk.check_out_item(out_item_t'{data: out_byte, data_valid: out_byte_valid,
                                     frame_end: out_frame_end, aborted: out_frame_aborted,
                                     inter: out_inter_coded, ts: out_frame_timestamp});
    end
  end

  // stimulus
  initial begin
    in_item_t it;
    bit       paused;
    chk = new();
    n_sent = 0;
    burst_left = 0;
    hold_req = 0;
    paused = 0;
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_payload_byte    <= 8'h00;
    in_first_of_packet <= 1'b0;
    in_last_of_packet  <= 1'b0;
    in_marker_bit      <= 1'b0;
    in_discontinuity   <= 1'b0;
    in_rtp_timestamp   <= 32'h0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // stray byte before any packet, every flag but first set
    it = '{data: 8'hFF, first: 1'b0, last: 1'b1, marker: 1'b1, disc: 1'b1, ts: '1};
    send(it);
    // mode a, ebit 3: the last byte is left as a partial byte
    pay_q = {8'hFF, 8'hA5};
    send_packet(hdr_first(MODE_A, 3'd0, 3'd3), 4, 1'b0, 1'b0, 32'h0, 1'b0);
    // mode b, sbit 3: partial byte merged, marker ends the frame
    pay_q = {8'h00};
    send_packet(hdr_first(MODE_B, 3'd3, 3'd0), 8, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0);
    // empty payload with marker while no frame is open
    pay_q = {};
    send_packet(hdr_first(MODE_A, 3'd0, 3'd0), 4, 1'b1, 1'b0, $urandom, 1'b0);
    // empty payload again, frame open with no bytes: bare end item
    send_packet(hdr_first(MODE_A, 3'd7, 3'd7), 4, 1'b1, 1'b0, $urandom, 1'b0);
    // mode c cut inside its header, discontinuity on its first byte
    send_packet(hdr_first(MODE_C, 3'd7, 3'd7), 2, 1'b1, 1'b1, $urandom, 1'b0);
    // stray byte after the last one of a packet
    it = '{data: 8'h00, first: 1'b0, last: 1'b1, marker: 1'b1, disc: 1'b1, ts: 32'h0};
    send(it);
    wait_drained();

    // random frames mixed with noise
    while (n_sent < 295) begin
      if (!hold_req && n_sent > 130) hold_req = 1;
      if (!paused && n_sent > 240) begin
        wait_drained();
        paused = 1;
      end
      if ($urandom_range(0, 9) < 7) send_frame();
      else send_noise();
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("h263_rtp_depacketizer_core: match");
    end else begin
      $display("h263_rtp_depacketizer_core: mismatch");
    end
    $finish;
  end

endmodule

/* h263_rtp_depacketizer_core.f */
rtl/h263d_pkg.sv
rtl/h263d_front.sv
rtl/h263d_cmd_q.sv
rtl/h263d_back.sv
rtl/h263_rtp_depacketizer_core.sv
tb/h263d_tb_pkg.sv
tb/tb_top.sv
